// File: sv/mi4_pkg.sv
// Shared types, constants and the cofactor term table for the 4x4 inverse core.
package mi4_pkg;

	localparam int ELEM_W        = 32;
	localparam int ELEMS         = 16;
	localparam int IDX_W         = 4;
	localparam int MIN_DET_W     = 31;
	localparam int ADJ_W         = 100;
	localparam int DET_W         = 134;
	localparam int LIMB_W        = 32;
	localparam int P_W           = 128;
	localparam int R_W           = 160;
	localparam int Q_W           = 33;
	localparam int BIT_W         = 6;
	localparam int TDATA_OUT_W   = 40;
	localparam int TUSER_OUT_W   = 2;
	localparam int FRAC_BITS_DEF = 16;
	localparam int TERMS         = 6;

	localparam logic [MIN_DET_W-1:0] MIN_DET_RST = 31'd1;
	localparam logic                 REG_MIN_DET = 1'b0;
	localparam logic [ELEM_W-1:0]    VAL_POS_SAT = 32'h7FFF_FFFF;
	localparam logic [ELEM_W-1:0]    VAL_NEG_SAT = 32'h8000_0000;
	localparam logic [Q_W-1:0]       Q_POS_MAX   = 33'h0_7FFF_FFFF;
	localparam logic [Q_W-1:0]       Q_NEG_MAX   = 33'h0_8000_0000;

	typedef enum logic [4:0] {
		ST_LOAD, ST_RD0, ST_LDP, ST_MUL1, ST_MVP, ST_MULH, ST_MULL, ST_ACC, ST_STORE,
		ST_DRD, ST_DMUL, ST_DACC, ST_CHK, ST_TEST, ST_SING,
		ST_VPREP, ST_VSTART, ST_VSTEP, ST_VOUT
	} state_t;

	typedef enum logic [1:0] {P_HOLD, P_RAM, P_RES, P_ADJ} psel_t;

	typedef struct packed {
		logic [IDX_W-1:0] a0;
		logic [IDX_W-1:0] a1;
		logic [IDX_W-1:0] a2;
		logic             neg;
	} term_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		psel_t            p_sel;
		logic             mul_en;
		logic             mul_first;
		logic [1:0]       mul_limb;
		logic             acc_en;
		logic             acc_set;
		logic             acc_neg;
		logic             adj_wr;
		logic [IDX_W-1:0] adj_idx;
		logic             det_en;
		logic             det_first;
		logic             chk;
		logic             div_prep;
		logic             div_start;
		logic             div_step;
		logic             out_wr;
		logic             out_sing;
		logic             out_last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic singular;
	} sts_t;

	// One signed triple product of the 3x3 minor for cofactor k = row*4+col.
	function automatic term_t cof_term(input logic [IDX_W-1:0] k, input logic [2:0] t);
		logic [1:0] r;
		logic [1:0] c;
		logic [1:0] rr [3];
		logic [1:0] cc [3];
		logic [1:0] pm [3];
		logic       pn;
		term_t      o;
		r = k[3:2];
		c = k[1:0];
		for (int j = 0; j < 3; j++) begin
			rr[j] = (2'(j) < r) ? 2'(j) : 2'(j + 1);
			cc[j] = (2'(j) < c) ? 2'(j) : 2'(j + 1);
		end
		unique case (t)
			3'd0: begin pm[0] = 2'd0; pm[1] = 2'd1; pm[2] = 2'd2; pn = 1'b0; end
			3'd1: begin pm[0] = 2'd0; pm[1] = 2'd2; pm[2] = 2'd1; pn = 1'b1; end
			3'd2: begin pm[0] = 2'd1; pm[1] = 2'd0; pm[2] = 2'd2; pn = 1'b1; end
			3'd3: begin pm[0] = 2'd1; pm[1] = 2'd2; pm[2] = 2'd0; pn = 1'b0; end
			3'd4: begin pm[0] = 2'd2; pm[1] = 2'd0; pm[2] = 2'd1; pn = 1'b0; end
			3'd5: begin pm[0] = 2'd2; pm[1] = 2'd1; pm[2] = 2'd0; pn = 1'b1; end
			default: begin pm[0] = 2'd0; pm[1] = 2'd1; pm[2] = 2'd2; pn = 1'b0; end
		endcase
		o.a0  = {rr[0], cc[pm[0]]};
		o.a1  = {rr[1], cc[pm[1]]};
		o.a2  = {rr[2], cc[pm[2]]};
		o.neg = pn ^ r[0] ^ c[0];
		return o;
	endfunction

endpackage

// File: sv/mi4_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mi4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/mi4_ctrl.sv
// Sequencer for loading, cofactor and determinant passes, and the per-entry divide.
module mi4_ctrl import mi4_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] load_q, load_d;
	logic [IDX_W-1:0] cof_q, cof_d;
	logic [2:0]       term_q, term_d;
	logic [1:0]       limb_q, limb_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	term_t            tm;

	assign tm = cof_term(cof_q, term_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_q  <= '0;
			cof_q   <= '0;
			term_q  <= '0;
			limb_q  <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			load_q  <= load_d;
			cof_q   <= cof_d;
			term_q  <= term_d;
			limb_q  <= limb_d;
			bit_q   <= bit_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		load_d        = load_q;
		cof_d         = cof_q;
		term_d        = term_q;
		limb_d        = limb_q;
		bit_d         = bit_q;
		cmd           = '0;
		cmd.p_sel     = P_HOLD;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = load_q;
					load_d      = load_q + 1'b1;
					if (load_q == IDX_W'(ELEMS - 1)) begin
						cof_d   = '0;
						term_d  = '0;
						state_d = ST_RD0;
					end
				end
			end
			ST_RD0: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = tm.a0;
				state_d     = ST_LDP;
			end
			ST_LDP: begin
				cmd.p_sel   = P_RAM;
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = tm.a1;
				state_d     = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_first = 1'b1;
				cmd.mul_limb  = 2'd0;
				cmd.rd_en     = 1'b1;
				cmd.rd_addr   = tm.a2;
				state_d       = ST_MVP;
			end
			ST_MVP: begin
				cmd.p_sel = P_RES;
				state_d   = ST_MULH;
			end
			ST_MULH: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_first = 1'b1;
				cmd.mul_limb  = 2'd1;
				state_d       = ST_MULL;
			end
			ST_MULL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_limb = 2'd0;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en  = 1'b1;
				cmd.acc_set = (term_q == '0);
				cmd.acc_neg = tm.neg;
				if (term_q == 3'(TERMS - 1)) begin
					state_d = ST_STORE;
				end else begin
					term_d  = term_q + 1'b1;
					state_d = ST_RD0;
				end
			end
			ST_STORE: begin
				// cofactor (r,c) lands at c*4+r: the adjugate
				cmd.adj_wr  = 1'b1;
				cmd.adj_idx = {cof_q[1:0], cof_q[3:2]};
				term_d      = '0;
				if (cof_q == IDX_W'(ELEMS - 1)) begin
					cof_d   = '0;
					state_d = ST_DRD;
				end else begin
					cof_d   = cof_q + 1'b1;
					state_d = ST_RD0;
				end
			end
			ST_DRD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = {2'b00, cof_q[1:0]};
				cmd.p_sel   = P_ADJ;
				cmd.adj_idx = {cof_q[1:0], 2'b00};
				limb_d      = 2'd3;
				state_d     = ST_DMUL;
			end
			ST_DMUL: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_first = (limb_q == 2'd3);
				cmd.mul_limb  = limb_q;
				limb_d        = limb_q - 1'b1;
				if (limb_q == 2'd0) begin
					state_d = ST_DACC;
				end
			end
			ST_DACC: begin
				cmd.det_en    = 1'b1;
				cmd.det_first = (cof_q == '0);
				if (cof_q == IDX_W'(3)) begin
					state_d = ST_CHK;
				end else begin
					cof_d   = cof_q + 1'b1;
					state_d = ST_DRD;
				end
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				cof_d = '0;
				if (sts.singular) begin
					state_d = ST_SING;
				end else begin
					state_d = ST_VPREP;
				end
			end
			ST_SING: begin
				if (sts.out_free) begin
					cmd.out_wr   = 1'b1;
					cmd.out_sing = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = ST_LOAD;
				end
			end
			ST_VPREP: begin
				cmd.div_prep = 1'b1;
				cmd.adj_idx  = cof_q;
				state_d      = ST_VSTART;
			end
			ST_VSTART: begin
				cmd.div_start = 1'b1;
				bit_d         = '0;
				state_d       = ST_VSTEP;
			end
			ST_VSTEP: begin
				cmd.div_step = 1'b1;
				bit_d        = bit_q + 1'b1;
				if (bit_q == BIT_W'(Q_W - 1)) begin
					state_d = ST_VOUT;
				end
			end
			ST_VOUT: begin
				cmd.adj_idx = cof_q;
				if (sts.out_free) begin
					cmd.out_wr   = 1'b1;
					cmd.out_last = (cof_q == IDX_W'(ELEMS - 1));
					cof_d        = cof_q + 1'b1;
					if (cof_q == IDX_W'(ELEMS - 1)) begin
						state_d = ST_LOAD;
					end else begin
						state_d = ST_VPREP;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

`ifndef SYNTH
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_wr |-> sts.out_free)
		else $error("result written over an untaken word");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> (load_q == '0))
		else $error("element count not at zero while computing");

	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_wr && !cmd.out_last) |=> (state_q != ST_LOAD))
		else $error("run ended before its last result");
`endif

endmodule

// File: sv/mi4_dp.sv
// Datapath: element RAM, limb-serial multiplier, cofactor and determinant sums, divider.
module mi4_dp import mi4_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic [ELEM_W-1:0]      in_data,
	input  logic [MIN_DET_W-1:0]   min_det,
	input  logic                   m_axis_tready,
	output logic                   m_axis_tvalid,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,
	output logic [TUSER_OUT_W-1:0] m_axis_tuser,
	output logic                   m_axis_tlast
);

	localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
	localparam int CMP_W = (NUM_W - Q_W > DET_W) ? NUM_W - Q_W : DET_W;

	logic signed [ELEM_W-1:0]          rd_data;
	logic signed [P_W-1:0]             p_q;
	logic signed [R_W-1:0]             r_q;
	logic signed [ADJ_W-1:0]           acc_q;
	logic signed [ADJ_W-1:0]           adj_q [ELEMS];
	logic signed [DET_W-1:0]           det_q;
	logic [DET_W-1:0]                  dmag_q;
	logic [NUM_W-1:0]                  num_q;
	logic [DET_W-1:0]                  rem_q;
	logic [Q_W-1:0]                    qs_q;
	logic                              neg_q;
	logic                              ovf_q;
	logic                              out_valid_q;
	logic [ELEM_W-1:0]                 out_value_q;
	logic [IDX_W-1:0]                  out_index_q;
	logic                              out_sing_q;
	logic                              out_sat_q;
	logic                              out_last_q;

	logic signed [ADJ_W-1:0]           adj_rd;
	logic [LIMB_W-1:0]                 limb;
	logic signed [LIMB_W:0]            limb_x;
	logic signed [LIMB_W+ELEM_W:0]     prod;
	logic signed [R_W-1:0]             prod_x;
	logic signed [R_W-1:0]             r_base;
	logic signed [ADJ_W-1:0]           rt;
	logic signed [ADJ_W-1:0]           acc_term;
	logic signed [ADJ_W-1:0]           acc_base;
	logic signed [DET_W-1:0]           det_base;
	logic [ADJ_W-1:0]                  adj_mag;
	logic [DET_W-1:0]                  thr;
	logic [DET_W:0]                    rem_x;
	logic [DET_W:0]                    rem_sub;
	logic                              ge;
	logic [NUM_W-1:0]                  num_hi;
	logic                              ovf_c;
	logic                              sat_c;
	logic [ELEM_W-1:0]                 val_c;

	mi4_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(ELEMS)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(cmd.wr_addr),
		.wr_data(in_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(cmd.rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		adj_rd   = adj_q[cmd.adj_idx];
		// top limb of the running product is signed, lower limbs are not
		limb     = p_q[{cmd.mul_limb, 5'd0} +: LIMB_W];
		limb_x   = {cmd.mul_first & limb[LIMB_W-1], limb};
		prod     = limb_x * rd_data;
		prod_x   = prod;
		r_base   = cmd.mul_first ? '0 : (r_q <<< LIMB_W);
		rt       = r_q[ADJ_W-1:0];
		acc_term = cmd.acc_neg ? -rt : rt;
		acc_base = cmd.acc_set ? '0 : acc_q;
		det_base = cmd.det_first ? '0 : det_q;
		adj_mag  = adj_rd[ADJ_W-1] ? ADJ_W'(-adj_rd) : ADJ_W'(adj_rd);
		thr      = DET_W'(min_det) << (3 * FRAC_BITS);
		rem_x    = {rem_q, qs_q[Q_W-1]};
		rem_sub  = rem_x - {1'b0, dmag_q};
		ge       = (rem_x >= {1'b0, dmag_q});
		num_hi   = num_q >> Q_W;
		ovf_c    = (CMP_W'(num_hi) >= CMP_W'(dmag_q));
		if (neg_q) begin
			sat_c = ovf_q || (qs_q > Q_NEG_MAX);
			val_c = sat_c ? VAL_NEG_SAT : (ELEM_W'(0) - qs_q[ELEM_W-1:0]);
		end else begin
			sat_c = ovf_q || (qs_q > Q_POS_MAX);
			val_c = sat_c ? VAL_POS_SAT : qs_q[ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.p_sel)
			P_RAM:   p_q <= P_W'(rd_data);
			P_RES:   p_q <= r_q[P_W-1:0];
			P_ADJ:   p_q <= P_W'(adj_rd);
			default: p_q <= p_q;
		endcase
		if (cmd.mul_en) begin
			r_q <= r_base + prod_x;
		end
		if (cmd.acc_en) begin
			acc_q <= acc_base + acc_term;
		end
		if (cmd.adj_wr) begin
			adj_q[cmd.adj_idx] <= acc_q;
		end
		if (cmd.det_en) begin
			det_q <= det_base + r_q[DET_W-1:0];
		end
		if (cmd.chk) begin
			dmag_q <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
		end
		if (cmd.div_prep) begin
			num_q <= NUM_W'(adj_mag) << (2 * FRAC_BITS);
			neg_q <= adj_rd[ADJ_W-1] ^ det_q[DET_W-1];
		end
		if (cmd.div_start) begin
			ovf_q <= ovf_c;
			rem_q <= DET_W'(num_hi);
			qs_q  <= num_q[Q_W-1:0];
		end
		// restoring step: numerator bits shift out of the top, quotient bits in at the bottom
		if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[DET_W-1:0] : rem_x[DET_W-1:0];
			qs_q  <= {qs_q[Q_W-2:0], ge};
		end
		if (cmd.out_wr) begin
			out_value_q <= cmd.out_sing ? '0 : val_c;
			out_index_q <= cmd.out_sing ? '0 : cmd.adj_idx;
			out_sing_q  <= cmd.out_sing;
			out_sat_q   <= cmd.out_sing ? 1'b0 : sat_c;
			out_last_q  <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_wr) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || m_axis_tready;
	assign sts.singular = (dmag_q == '0) || (dmag_q < thr);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_OUT_W - ELEM_W - IDX_W){1'b0}}, out_index_q, out_value_q};
	assign m_axis_tuser  = {out_sat_q, out_sing_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// File: sv/matrix_inverse_4x4_core.sv
// Top level: 4x4 fixed-point inverse by cofactors, APB threshold register.
// Loading takes one element per cycle; s_axis_tready stays low from the 16th element until the last result is written.
// After the 16th element: 96 triple products through one 33x32 multiplier, then the determinant,
// then a 33-step restoring divide for each entry in turn.
// A singular matrix ends earlier, with a single result word flagged singular.
// Reset (arst_n, asynchronous) returns the sequencer to loading at element 0 and min_det to 1.
module matrix_inverse_4x4_core import mi4_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [ELEM_W-1:0]      s_axis_tdata,   // [31:0] element_value
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [31:0] out_value, [35:32] out_index
	output logic [TUSER_OUT_W-1:0] m_axis_tuser,   // [0] singular, [1] saturated
	output logic                   m_axis_tlast,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic [MIN_DET_W-1:0] min_det_q;
	cmd_t                 cmd;
	sts_t                 sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_det_q <= MIN_DET_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MIN_DET)) begin
			min_det_q <= pwdata[MIN_DET_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_DET) ? {1'b0, min_det_q} : '0;

	mi4_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.sts          (sts),
		.cmd          (cmd)
	);

	mi4_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_data      (s_axis_tdata),
		.min_det      (min_det_q),
		.m_axis_tready(m_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

// File: tb/sv/matrix_inverse_4x4_core_test.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse core.
`timescale 1ns / 1ps

module matrix_inverse_4x4_core_test;
	import mi4_pkg::*;

	localparam int F        = FRAC_BITS_DEF;
	localparam int WW       = 256;
	localparam int SETTLE   = 1500;
	localparam logic [2:0] ADDR_MIN_DET = 3'(REG_MIN_DET) << 2;

	typedef struct {
		logic [31:0] value;
		logic [3:0]  index;
		logic        singular;
		logic        saturated;
		logic        last;
	} inv_word_t;

	typedef struct {
		logic [31:0] data;
		logic        has_known;
		logic [31:0] known_value;
		logic        known_sing;
		logic        known_sat;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [ELEM_W-1:0]      s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic [TUSER_OUT_W-1:0] m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [2:0]             paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;

	matrix_inverse_4x4_core u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

	// predictor state
	logic signed [31:0] elems [16];
	int unsigned        fill_idx = 0;
	logic [30:0]        thresh = MIN_DET_RST;
	inv_word_t          inverse_q [$];
	int                 errors = 0;
	int                 tx_idle = 0;
	int                 rx_idle = 0;

	// minor row/col skip helper
	function automatic int pick(input int skip, input int j);
		return (j < skip) ? j : j + 1;
	endfunction

	function automatic logic signed [WW-1:0] cofac(input int r, input int c);
		int rr [3];
		int cc [3];
		logic signed [WW-1:0] m [3][3];
		logic signed [WW-1:0] acc;
		for (int j = 0; j < 3; j++) begin
			rr[j] = pick(r, j);
			cc[j] = pick(c, j);
		end
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				m[a][b] = WW'(elems[rr[a]*4 + cc[b]]);
		acc = m[0][0]*(m[1][1]*m[2][2] - m[1][2]*m[2][1])
			- m[0][1]*(m[1][0]*m[2][2] - m[1][2]*m[2][0])
			+ m[0][2]*(m[1][0]*m[2][1] - m[1][1]*m[2][0]);
		return ((r + c) % 2) ? -acc : acc;
	endfunction

	task automatic predict_inverse();
		logic signed [WW-1:0] adj [16];
		logic signed [WW-1:0] det;
		logic [WW-1:0]        dmag;
		logic [WW-1:0]        quo;
		logic [WW-1:0]        amag;
		inv_word_t            w;
		logic                 neg;
		det = '0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				adj[c*4 + r] = cofac(r, c);
		for (int c = 0; c < 4; c++)
			det += WW'(elems[c]) * adj[c*4];
		dmag = (det < 0) ? -det : det;
		if (det == 0 || dmag < (WW'(thresh) << (3*F))) begin
			w = '{32'd0, 4'd0, 1'b1, 1'b0, 1'b1};
			inverse_q.push_back(w);
			return;
		end
		for (int i = 0; i < 16; i++) begin
			neg  = (adj[i] < 0) != (det < 0);
			amag = (adj[i] < 0) ? -adj[i] : adj[i];
			quo  = (amag << (2*F)) / dmag;
			w.index = 4'(i); w.singular = 1'b0; w.last = (i == 15);
			if (neg) begin
				w.saturated = quo > 32'h8000_0000;
				w.value = w.saturated ? VAL_NEG_SAT : 32'(-quo);
			end else begin
				w.saturated = quo > 32'h7FFF_FFFF;
				w.value = w.saturated ? VAL_POS_SAT : quo[31:0];
			end
			inverse_q.push_back(w);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// check outgoing words against the queue
	always @(posedge clk) begin
		inv_word_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (inverse_q.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
			end else begin
				w = inverse_q.pop_front();
				if (m_axis_tdata[31:0] !== w.value)
					report_mismatch("value", m_axis_tdata[31:0], w.value);
				if (m_axis_tdata[35:32] !== w.index)
					report_mismatch("index", 32'(m_axis_tdata[35:32]), 32'(w.index));
				if (m_axis_tuser[0] !== w.singular)
					report_mismatch("singular", 32'(m_axis_tuser[0]), 32'(w.singular));
				if (m_axis_tuser[1] !== w.saturated)
					report_mismatch("saturated", 32'(m_axis_tuser[1]), 32'(w.saturated));
				if (m_axis_tlast !== w.last)
					report_mismatch("last", 32'(m_axis_tlast), 32'(w.last));
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle);
	end

	task automatic write_min_det(input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_MIN_DET; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		thresh = val[30:0];
	endtask

	// hold tvalid high across back-to-back words; drop it only while idling
	task automatic send_element(input logic [31:0] val);
		while ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= val;
		do @(posedge clk); while (!s_axis_tready);
		elems[fill_idx] = val;
		fill_idx = (fill_idx + 1) % 16;
		if (fill_idx == 0) predict_inverse();
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (inverse_q.size() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_elem(input int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(8 << F)) - (4 << F));
			default: return 32'($signed($urandom_range(512)) - 256);
		endcase
	endfunction

	stim_row_t plan [$];

	task automatic add_matrix(input logic [31:0] m [16], input logic known,
			input logic [31:0] kv, input logic ks, input logic kt);
		for (int i = 0; i < 16; i++)
			plan.push_back('{m[i], known && i == 15, kv, ks, kt});
	endtask

	initial begin
		logic [31:0] m [16];
		int          mode;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle = 18; rx_idle = 62;

		// directed: identity, zero matrix, diagonal extremes
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'd0;
		add_matrix(m, 1'b0, '0, 1'b0, 1'b0);
		for (int i = 0; i < 16; i++) m[i] = 32'd0;
		add_matrix(m, 1'b1, 32'd0, 1'b1, 1'b0);
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'd1 : 32'd0;
		add_matrix(m, 1'b0, '0, 1'b0, 1'b1);
		foreach (plan[k]) begin
			send_element(plan[k].data);
			if (plan[k].has_known) begin
				if (inverse_q[$].value !== plan[k].known_value ||
						inverse_q[$].singular !== plan[k].known_sing ||
						inverse_q[$].saturated !== plan[k].known_sat)
					report_mismatch("directed row", inverse_q[$].value,
						plan[k].known_value);
			end
		end
		for (int i = 0; i < 16; i++)
			m[i] = (i % 5 == 0) ? ((i == 0) ? 32'h7FFF_FFFF : 32'h8000_0000) : 32'd0;
		for (int i = 0; i < 16; i++) send_element(m[i]);
		drain();

		// threshold extremes: zero, maximum, mid, then back to the reset value
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_min_det(32'd0);
				1: write_min_det(32'h7FFF_FFFF);
				2: write_min_det(32'h0000_0100);
				default: write_min_det(32'(MIN_DET_RST));
			endcase
			if (ph == 1) begin tx_idle = 62; rx_idle = 18; end
			if (ph == 3) begin tx_idle = 0; rx_idle = 0; end
			for (int n = 0; n < 4; n++) begin
				mode = $urandom_range(2);
				for (int i = 0; i < 16; i++) send_element(rand_elem(mode));
			end
			// a rank-deficient matrix: two equal rows
			for (int i = 0; i < 16; i++) m[i] = rand_elem(1);
			for (int i = 0; i < 4; i++) m[12 + i] = m[4 + i];
			for (int i = 0; i < 16; i++) send_element(m[i]);
			drain();
		end

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
